// ===== hdl/rhc_pkg.sv =====
// Shared types for the RGB to HSV converter: sector code and per-stage control word.
`default_nettype none
package rhc_pkg;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rhc_sector_t;

  typedef struct packed {
    logic valid;
    logic grey;
    logic sat_full;
  } rhc_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/rhc_front.sv =====
// Front stages: find max and min, pick the hue sector, build dividends and divisors.
`default_nettype none
module rhc_front #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [COMPONENT_BITS-1:0]   up_red,
  input  wire logic [COMPONENT_BITS-1:0]   up_green,
  input  wire logic [COMPONENT_BITS-1:0]   up_blue,
  output rhc_pkg::rhc_ctl_t                down_ctl,
  input  wire logic                        down_ready,
  output logic [COMPONENT_BITS+2:0]        down_rem_h,
  output logic [COMPONENT_BITS+2:0]        down_den_h,
  output logic [COMPONENT_BITS+2:0]        down_rem_s,
  output logic [COMPONENT_BITS+2:0]        down_den_s,
  output logic [COMPONENT_BITS-1:0]        down_bright
);
  import rhc_pkg::*;

  localparam int W  = COMPONENT_BITS;
  localparam int DW = COMPONENT_BITS + 3;

  logic              s1_valid_r, s1_valid_nxt;
  logic [W-1:0]      s1_max_r, s1_max_nxt;
  logic [W-1:0]      s1_delta_r, s1_delta_nxt;
  logic [W:0]        s1_diff_r, s1_diff_nxt;
  rhc_sector_t       s1_sec_r, s1_sec_nxt;
  logic              s1_grey_r, s1_grey_nxt;
  logic              s1_full_r, s1_full_nxt;
  logic              s1_ready;
  logic [W-1:0]      min_c;

  rhc_ctl_t          s2_ctl_r, s2_ctl_nxt;
  logic [DW-1:0]     s2_rem_h_r, s2_rem_h_nxt;
  logic [DW-1:0]     s2_den_h_r, s2_den_h_nxt;
  logic [DW-1:0]     s2_rem_s_r, s2_rem_s_nxt;
  logic [DW-1:0]     s2_den_s_r, s2_den_s_nxt;
  logic [W-1:0]      s2_bright_r, s2_bright_nxt;
  logic              s2_ready;
  logic [DW-1:0]     d_ext, diff_ext;

  assign s2_ready = !s2_ctl_r.valid || down_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  always_comb begin
    if (up_red >= up_green && up_red >= up_blue) begin
      s1_sec_nxt  = SEC_RED;
      s1_max_nxt  = up_red;
      s1_diff_nxt = {1'b0, up_green} - {1'b0, up_blue};
    end else if (up_green >= up_blue) begin
      s1_sec_nxt  = SEC_GREEN;
      s1_max_nxt  = up_green;
      s1_diff_nxt = {1'b0, up_blue} - {1'b0, up_red};
    end else begin
      s1_sec_nxt  = SEC_BLUE;
      s1_max_nxt  = up_blue;
      s1_diff_nxt = {1'b0, up_red} - {1'b0, up_green};
    end
    min_c = up_red;
    if (up_green < min_c) min_c = up_green;
    if (up_blue < min_c) min_c = up_blue;
    s1_delta_nxt = s1_max_nxt - min_c;
    s1_grey_nxt  = (s1_max_nxt == min_c);
    s1_full_nxt  = (min_c == '0);
    s1_valid_nxt = s1_ready ? up_valid : s1_valid_r;
  end

  always_comb begin
    d_ext    = {3'b000, s1_delta_r};
    diff_ext = {{2{s1_diff_r[W]}}, s1_diff_r};
    s2_den_h_nxt = (d_ext << 2) + (d_ext << 1);
    case (s1_sec_r)
      SEC_RED:   s2_rem_h_nxt = s1_diff_r[W] ? s2_den_h_nxt + diff_ext : diff_ext;
      SEC_GREEN: s2_rem_h_nxt = (d_ext << 1) + diff_ext;
      SEC_BLUE:  s2_rem_h_nxt = (d_ext << 2) + diff_ext;
      default:   s2_rem_h_nxt = '0;
    endcase
    s2_rem_s_nxt       = d_ext;
    s2_den_s_nxt       = {3'b000, s1_max_r};
    s2_bright_nxt      = s1_max_r;
    s2_ctl_nxt.grey    = s1_grey_r;
    s2_ctl_nxt.sat_full = s1_full_r;
    s2_ctl_nxt.valid   = s2_ready ? s1_valid_r : s2_ctl_r.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_ctl_r.valid <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      s2_ctl_r.valid <= s2_ctl_nxt.valid;
    end
    if (s1_ready && up_valid) begin
      s1_max_r   <= s1_max_nxt;
      s1_delta_r <= s1_delta_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s1_sec_r   <= s1_sec_nxt;
      s1_grey_r  <= s1_grey_nxt;
      s1_full_r  <= s1_full_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_rem_h_r        <= s2_rem_h_nxt;
      s2_den_h_r        <= s2_den_h_nxt;
      s2_rem_s_r        <= s2_rem_s_nxt;
      s2_den_s_r        <= s2_den_s_nxt;
      s2_bright_r       <= s2_bright_nxt;
      s2_ctl_r.grey     <= s2_ctl_nxt.grey;
      s2_ctl_r.sat_full <= s2_ctl_nxt.sat_full;
    end
  end

  assign down_ctl    = s2_ctl_r;
  assign down_rem_h  = s2_rem_h_r;
  assign down_den_h  = s2_den_h_r;
  assign down_rem_s  = s2_rem_s_r;
  assign down_den_s  = s2_den_s_r;
  assign down_bright = s2_bright_r;

endmodule
`default_nettype wire

// ===== hdl/rhc_cell.sv =====
// Division cell: one restoring step for hue and saturation quotients, one word held.
`default_nettype none
module rhc_cell #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rhc_pkg::rhc_ctl_t           up_ctl,
  output logic                             up_ready,
  input  wire logic [COMPONENT_BITS+2:0]   up_rem_h,
  input  wire logic [COMPONENT_BITS+2:0]   up_den_h,
  input  wire logic [COMPONENT_BITS-1:0]   up_quo_h,
  input  wire logic [COMPONENT_BITS+2:0]   up_rem_s,
  input  wire logic [COMPONENT_BITS+2:0]   up_den_s,
  input  wire logic [COMPONENT_BITS-1:0]   up_quo_s,
  input  wire logic [COMPONENT_BITS-1:0]   up_bright,
  output rhc_pkg::rhc_ctl_t                down_ctl,
  input  wire logic                        down_ready,
  output logic [COMPONENT_BITS+2:0]        down_rem_h,
  output logic [COMPONENT_BITS+2:0]        down_den_h,
  output logic [COMPONENT_BITS-1:0]        down_quo_h,
  output logic [COMPONENT_BITS+2:0]        down_rem_s,
  output logic [COMPONENT_BITS+2:0]        down_den_s,
  output logic [COMPONENT_BITS-1:0]        down_quo_s,
  output logic [COMPONENT_BITS-1:0]        down_bright
);
  import rhc_pkg::*;

  localparam int W  = COMPONENT_BITS;
  localparam int DW = COMPONENT_BITS + 3;

  rhc_ctl_t        ctl_r, ctl_nxt;
  logic [DW-1:0]   rem_h_r, rem_h_nxt, den_h_r;
  logic [DW-1:0]   rem_s_r, rem_s_nxt, den_s_r;
  logic [W-1:0]    quo_h_r, quo_h_nxt, quo_s_r, quo_s_nxt, bright_r;
  logic [DW:0]     sh_h, sh_s, sub_h, sub_s;
  logic            ge_h, ge_s;

  assign up_ready = !ctl_r.valid || down_ready;

  always_comb begin
    sh_h  = {up_rem_h, 1'b0};
    sh_s  = {up_rem_s, 1'b0};
    sub_h = sh_h - {1'b0, up_den_h};
    sub_s = sh_s - {1'b0, up_den_s};
    ge_h  = (sh_h >= {1'b0, up_den_h});
    ge_s  = (sh_s >= {1'b0, up_den_s});
    rem_h_nxt = ge_h ? sub_h[DW-1:0] : sh_h[DW-1:0];
    rem_s_nxt = ge_s ? sub_s[DW-1:0] : sh_s[DW-1:0];
    quo_h_nxt = {up_quo_h[W-2:0], ge_h};
    quo_s_nxt = {up_quo_s[W-2:0], ge_s};
    ctl_nxt.valid    = up_ready ? up_ctl.valid : ctl_r.valid;
    ctl_nxt.grey     = up_ctl.grey;
    ctl_nxt.sat_full = up_ctl.sat_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    if (up_ready && up_ctl.valid) begin
      ctl_r.grey     <= ctl_nxt.grey;
      ctl_r.sat_full <= ctl_nxt.sat_full;
      rem_h_r        <= rem_h_nxt;
      den_h_r        <= up_den_h;
      quo_h_r        <= quo_h_nxt;
      rem_s_r        <= rem_s_nxt;
      den_s_r        <= up_den_s;
      quo_s_r        <= quo_s_nxt;
      bright_r       <= up_bright;
    end
  end

  assign down_ctl    = ctl_r;
  assign down_rem_h  = rem_h_r;
  assign down_den_h  = den_h_r;
  assign down_quo_h  = quo_h_r;
  assign down_rem_s  = rem_s_r;
  assign down_den_s  = den_s_r;
  assign down_quo_s  = quo_s_r;
  assign down_bright = bright_r;

endmodule
`default_nettype wire

// ===== hdl/rgb_to_hsv_converter.sv =====
// Top level: RGB to HSV pixel converter built from a chain of division cells.
// Stages: two front stages, one division cell per quotient bit and one output
// register. Throughput: one word per cycle while out_stall is low; every stage
// holds one word and fills bubbles.
// Reset: synchronous, active low; clears valid bits only, payload is not reset.
`default_nettype none
module rgb_to_hsv_converter #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [COMPONENT_BITS-1:0]   in_red,
  input  wire logic [COMPONENT_BITS-1:0]   in_green,
  input  wire logic [COMPONENT_BITS-1:0]   in_blue,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [COMPONENT_BITS-1:0]        out_hue,
  output logic [COMPONENT_BITS-1:0]        out_saturation,
  output logic [COMPONENT_BITS-1:0]        out_brightness
);
  import rhc_pkg::*;

  localparam int W  = COMPONENT_BITS;
  localparam int DW = COMPONENT_BITS + 3;

  rhc_ctl_t        ctl   [0:W];
  logic            rdy   [0:W];
  logic [DW-1:0]   rem_h [0:W];
  logic [DW-1:0]   den_h [0:W];
  logic [W-1:0]    quo_h [0:W];
  logic [DW-1:0]   rem_s [0:W];
  logic [DW-1:0]   den_s [0:W];
  logic [W-1:0]    quo_s [0:W];
  logic [W-1:0]    bright[0:W];
  logic            front_ready;

  logic            out_valid_r, out_valid_nxt;
  logic [W-1:0]    hue_r, hue_nxt, sat_r, sat_nxt, bri_r;
  logic            out_ready;

  assign in_stall = !front_ready;

  rhc_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (front_ready),
    .up_red     (in_red),
    .up_green   (in_green),
    .up_blue    (in_blue),
    .down_ctl   (ctl[0]),
    .down_ready (rdy[0]),
    .down_rem_h (rem_h[0]),
    .down_den_h (den_h[0]),
    .down_rem_s (rem_s[0]),
    .down_den_s (den_s[0]),
    .down_bright(bright[0])
  );

  assign quo_h[0] = '0;
  assign quo_s[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    rhc_cell #(.COMPONENT_BITS(COMPONENT_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_ctl     (ctl[i]),
      .up_ready   (rdy[i]),
      .up_rem_h   (rem_h[i]),
      .up_den_h   (den_h[i]),
      .up_quo_h   (quo_h[i]),
      .up_rem_s   (rem_s[i]),
      .up_den_s   (den_s[i]),
      .up_quo_s   (quo_s[i]),
      .up_bright  (bright[i]),
      .down_ctl   (ctl[i+1]),
      .down_ready (rdy[i+1]),
      .down_rem_h (rem_h[i+1]),
      .down_den_h (den_h[i+1]),
      .down_quo_h (quo_h[i+1]),
      .down_rem_s (rem_s[i+1]),
      .down_den_s (den_s[i+1]),
      .down_quo_s (quo_s[i+1]),
      .down_bright(bright[i+1])
    );
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign rdy[W]    = out_ready;

  always_comb begin
    out_valid_nxt = out_ready ? ctl[W].valid : out_valid_r;
    hue_nxt = ctl[W].grey ? '0 : quo_h[W];
    if (ctl[W].grey) begin
      sat_nxt = '0;
    end else if (ctl[W].sat_full) begin
      sat_nxt = '1;
    end else begin
      sat_nxt = quo_s[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && ctl[W].valid) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      bri_r <= bright[W];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bri_r;

  // keep remainders and divisors of the last cell observed by nothing else
  logic unused_tail;
  assign unused_tail = ^{rem_h[W], den_h[W], rem_s[W], den_s[W]};

endmodule
`default_nettype wire

// ===== hdl/rhc_checker.sv =====
// Port checker for the RGB to HSV converter and its bind to the top level.
`default_nettype none
module rhc_checker #(
  parameter int COMPONENT_BITS = 16
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [COMPONENT_BITS-1:0]   in_red,
  input wire logic [COMPONENT_BITS-1:0]   in_green,
  input wire logic [COMPONENT_BITS-1:0]   in_blue,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [COMPONENT_BITS-1:0]   out_hue,
  input wire logic [COMPONENT_BITS-1:0]   out_saturation,
  input wire logic [COMPONENT_BITS-1:0]   out_brightness
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue) &&
      $stable(out_saturation) && $stable(out_brightness))
    else $error("stalled output word changed");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_hue == '0 && out_saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation == '0 |-> out_hue == '0)
    else $error("zero saturation with nonzero hue");

  logic unused_in;
  assign unused_in = ^{in_valid, in_stall, in_red, in_green, in_blue};

endmodule

bind rgb_to_hsv_converter rhc_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_rhc_checker (.*);
`default_nettype wire
